// ===== rtl/lpfs_pkg.sv =====
// ============================================================================
// lpfs_pkg
// Shared types and constants for the length-prefixed frame splitter.
// ============================================================================
package lpfs_pkg;

    localparam int unsigned HEADER_BYTES = 8;
    localparam logic [24:0] MAX_LIMIT = 25'd16777216;
    localparam logic [24:0] MAX_RESET = 25'd65536;

    typedef enum logic [3:0] {
        PH_LENGTH  = 4'b0001,
        PH_PROTO   = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_HALT    = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [0:0] {
        REG_MAX_FRAME = 1'b0
    } t_reg_index;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] protocol_id;
        logic [7:0]  data_byte;
        logic [23:0] payload_length;
        logic        last;
    } t_result;

endpackage

// ===== rtl/length_prefixed_frame_splitter.sv =====
// ============================================================================
// length_prefixed_frame_splitter
// Splits a byte stream of length-prefixed frames into tagged payload words.
// ============================================================================
// Channel   Direction  Handshake           Word
// input     in         i_valid / o_stall   i_rx_byte, i_restart
// output    out        o_valid / i_stall   o_kind, o_protocol_id, o_data_byte,
//                                          o_payload_length, o_last
// config    in         APB                 max_frame_bytes at byte address 0
//
// One input word is taken every cycle while o_stall is low, a rate set by the
// combinational header/payload update; results are registered in lpfs_skid.
// o_stall rises only while the skid entry holds a word, which happens after
// the output has been stalled with a new result arriving behind it.
// Reset is synchronous and clears the phase, counters and both output slots.
// ============================================================================
module length_prefixed_frame_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [31:0] o_protocol_id,
    output logic [7:0]  o_data_byte,
    output logic [23:0] o_payload_length,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lpfs_pkg::t_phase  r_phase, n_phase;
    logic [1:0]        r_hcount, n_hcount;
    logic [23:0]       r_len_low, n_len_low;
    logic [31:0]       r_proto, n_proto;
    logic [23:0]       r_plen, n_plen;
    logic [23:0]       r_left, n_left;
    logic [24:0]       r_max;
    logic              n_accept;
    logic              n_push;
    lpfs_pkg::t_result n_result;
    lpfs_pkg::t_result w_out;
    logic [31:0]       n_full_len;
    logic [24:0]       n_limit;
    logic [31:0]       n_plen_wide;
    logic              n_cfg_hit;

    // Configuration port.
    assign pready    = 1'b1;
    assign n_cfg_hit = (paddr[2] == lpfs_pkg::REG_MAX_FRAME);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= lpfs_pkg::MAX_RESET;
        end else if (psel && penable && pwrite && n_cfg_hit) begin
            r_max <= pwdata[24:0];
        end
    end

    assign prdata = n_cfg_hit ? {7'd0, r_max} : 32'd0;

    assign n_accept    = i_valid && !o_stall;
    assign n_full_len  = {i_rx_byte, r_len_low};
    assign n_limit     = (r_max > lpfs_pkg::MAX_LIMIT) ? lpfs_pkg::MAX_LIMIT : r_max;
    assign n_plen_wide = n_full_len - 32'(lpfs_pkg::HEADER_BYTES);

    always_comb begin
        n_phase   = r_phase;
        n_hcount  = r_hcount;
        n_len_low = r_len_low;
        n_proto   = r_proto;
        n_plen    = r_plen;
        n_left    = r_left;
        n_push    = 1'b0;
        n_result  = '0;

        if (i_restart) begin
            n_phase   = lpfs_pkg::PH_LENGTH;
            n_hcount  = 2'd0;
            n_len_low = 24'd0;
            n_proto   = 32'd0;
            n_plen    = 24'd0;
            n_left    = 24'd0;
        end else begin
            unique case (r_phase)
                lpfs_pkg::PH_LENGTH: begin
                    n_hcount = r_hcount + 2'd1;
                    case (r_hcount)
                        2'd0: n_len_low = {16'd0, i_rx_byte};
                        2'd1: n_len_low[15:8] = i_rx_byte;
                        2'd2: n_len_low[23:16] = i_rx_byte;
                        default: begin
                            if (i_rx_byte[7] || (n_full_len < 32'(lpfs_pkg::HEADER_BYTES))
                                    || (n_full_len > {7'd0, n_limit})) begin
                                n_phase              = lpfs_pkg::PH_HALT;
                                n_push               = 1'b1;
                                n_result.kind        = lpfs_pkg::KIND_ERROR;
                                n_result.last        = 1'b1;
                            end else begin
                                n_phase = lpfs_pkg::PH_PROTO;
                                n_plen  = n_plen_wide[23:0];
                            end
                        end
                    endcase
                end
                lpfs_pkg::PH_PROTO: begin
                    n_hcount = r_hcount + 2'd1;
                    case (r_hcount)
                        2'd0: n_proto = {24'd0, i_rx_byte};
                        2'd1: n_proto[15:8] = i_rx_byte;
                        2'd2: n_proto[23:16] = i_rx_byte;
                        default: begin
                            n_proto[31:24] = i_rx_byte;
                            n_left         = r_plen;
                            if (r_plen == 24'd0) begin
                                n_phase              = lpfs_pkg::PH_LENGTH;
                                n_push               = 1'b1;
                                n_result.kind        = lpfs_pkg::KIND_EMPTY;
                                n_result.protocol_id = {i_rx_byte, r_proto[23:0]};
                                n_result.last        = 1'b1;
                            end else begin
                                n_phase = lpfs_pkg::PH_PAYLOAD;
                            end
                        end
                    endcase
                end
                lpfs_pkg::PH_PAYLOAD: begin
                    n_push                  = 1'b1;
                    n_result.kind           = lpfs_pkg::KIND_DATA;
                    n_result.protocol_id    = r_proto;
                    n_result.data_byte      = i_rx_byte;
                    n_result.payload_length = r_plen;
                    n_result.last           = (r_left <= 24'd1);
                    n_left                  = r_left - 24'd1;
                    if (r_left <= 24'd1) begin
                        n_left   = 24'd0;
                        n_hcount = 2'd0;
                        n_phase  = lpfs_pkg::PH_LENGTH;
                    end
                end
                lpfs_pkg::PH_HALT: begin
                end
                default: begin
                    n_phase = lpfs_pkg::PH_HALT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= lpfs_pkg::PH_LENGTH;
            r_hcount <= 2'd0;
            r_plen   <= 24'd0;
            r_left   <= 24'd0;
        end else if (n_accept) begin
            r_phase  <= n_phase;
            r_hcount <= n_hcount;
            r_plen   <= n_plen;
            r_left   <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_len_low <= n_len_low;
            r_proto   <= n_proto;
        end
    end

    lpfs_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (n_accept && n_push),
        .i_result (n_result),
        .o_full   (o_stall),
        .o_valid  (o_valid),
        .o_result (w_out),
        .i_stall  (i_stall)
    );

    assign o_kind           = w_out.kind;
    assign o_protocol_id    = w_out.protocol_id;
    assign o_data_byte      = w_out.data_byte;
    assign o_payload_length = w_out.payload_length;
    assign o_last           = w_out.last;

endmodule

// ===== rtl/lpfs_skid.sv =====
// ============================================================================
// lpfs_skid
// Output register with one skid entry, so that a word can be taken upstream
// while the previous result still waits downstream.
// ============================================================================
module lpfs_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lpfs_pkg::t_result  i_result,
    output logic               o_full,
    output logic               o_valid,
    output lpfs_pkg::t_result  o_result,
    input  logic               i_stall
);

    logic              r_out_valid;
    logic              r_skid_valid;
    lpfs_pkg::t_result r_out;
    lpfs_pkg::t_result r_skid;
    logic              n_take;
    logic              n_out_free;

    assign n_take     = r_out_valid && !i_stall;
    assign n_out_free = !r_out_valid || n_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (n_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (n_out_free) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (n_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (n_take) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (n_out_free) begin
                r_out <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== rtl/lpfs_checker.sv =====
// ============================================================================
// lpfs_checker
// Port-level checks for the length-prefixed frame splitter.
// ============================================================================
module lpfs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [31:0] o_protocol_id,
    input logic [7:0]  o_data_byte,
    input logic [23:0] o_payload_length,
    input logic        o_last
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_protocol_id)
            && $stable(o_data_byte) && $stable(o_payload_length) && $stable(o_last))
        else $error("stalled output word changed");

    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == lpfs_pkg::KIND_ERROR |-> o_last && o_protocol_id == 32'd0
            && o_payload_length == 24'd0 && o_data_byte == 8'd0)
        else $error("malformed error word");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == lpfs_pkg::KIND_EMPTY |-> o_last && o_payload_length == 24'd0
            && o_data_byte == 8'd0)
        else $error("malformed empty-frame word");

    a_data_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == lpfs_pkg::KIND_DATA |-> o_payload_length != 24'd0)
        else $error("payload word with zero payload length");

endmodule

bind length_prefixed_frame_splitter lpfs_checker u_lpfs_checker (.*);
